// ===== rtl/cpfm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpfm_pkg
// Shared constants, codes and types of the copy-on-write page frame manager.
// ----------------------------------------------------------------------------
package cpfm_pkg;

   localparam int NUM_FRAMES   = 128;
   localparam int PTES_PER_DIR = 16;
   localparam int MAX_PROCS    = 8;

   localparam int TABLE_PAGES = PTES_PER_DIR * PTES_PER_DIR;
   localparam int PAGES_KEPT  = (TABLE_PAGES < 256) ? TABLE_PAGES : 256;

   localparam int KIND_W  = 2;
   localparam int VPN_W   = 8;
   localparam int PID_W   = 8;
   localparam int STAT_W  = 2;
   localparam int PFN_W   = 7;
   localparam int COUNT_W = 4;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

   localparam int FRAME_W  = $clog2(NUM_FRAMES);
   localparam int PAGE_W   = $clog2(PAGES_KEPT);
   localparam int SLOT_W   = $clog2(MAX_PROCS);
   localparam int ENTRY_W  = FRAME_W + 3;
   localparam int PADDR_W  = SLOT_W + PAGE_W;
   localparam int PDEPTH   = MAX_PROCS * PAGES_KEPT;

   localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FAULT  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_SWITCH = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_NO_FRAME = 2'd1;
   localparam logic [STAT_W-1:0] ST_NO_FAULT = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NONE    = 4'd0;
   localparam logic [OP_W-1:0] OP_CLEAR   = 4'd1;
   localparam logic [OP_W-1:0] OP_ACCEPT  = 4'd2;
   localparam logic [OP_W-1:0] OP_PREAD   = 4'd3;
   localparam logic [OP_W-1:0] OP_PENT    = 4'd4;
   localparam logic [OP_W-1:0] OP_PCNT    = 4'd5;
   localparam logic [OP_W-1:0] OP_SCAN    = 4'd6;
   localparam logic [OP_W-1:0] OP_DOWN    = 4'd7;
   localparam logic [OP_W-1:0] OP_UP      = 4'd8;
   localparam logic [OP_W-1:0] OP_FREE    = 4'd9;
   localparam logic [OP_W-1:0] OP_UPGRADE = 4'd10;
   localparam logic [OP_W-1:0] OP_SWITCH  = 4'd11;
   localparam logic [OP_W-1:0] OP_FRD     = 4'd12;
   localparam logic [OP_W-1:0] OP_FENT    = 4'd13;
   localparam logic [OP_W-1:0] OP_FCNT    = 4'd14;
   localparam logic [OP_W-1:0] OP_FEND    = 4'd15;

   localparam int PSEL_W = 2;
   localparam logic [PSEL_W-1:0] PSEL_ZERO  = 2'd0;
   localparam logic [PSEL_W-1:0] PSEL_FREE  = 2'd1;
   localparam logic [PSEL_W-1:0] PSEL_ENTRY = 2'd2;
   localparam logic [PSEL_W-1:0] PSEL_HOLD  = 2'd3;

   typedef struct packed {
      logic               valid;
      logic               writable;
      logic               cow;
      logic [FRAME_W-1:0] frame;
   } page_entry_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [STAT_W-1:0] code;
      logic [PSEL_W-1:0] psel;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              vpn_bad;
      logic              e_valid;
      logic              e_cow;
      logic              cnt_zero;
      logic              cnt_gt1;
      logic              scan_found;
      logic              scan_end;
      logic              sw_match;
      logic              sw_full;
      logic              walk_last;
   } ctrl_stat_type;

endpackage

// ===== rtl/cpfm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpfm_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module cpfm_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/cpfm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpfm_ctrl
// Controller that sequences every item through the datapath.
// ----------------------------------------------------------------------------
module cpfm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  cpfm_pkg::ctrl_stat_type stat,
   output cpfm_pkg::ctrl_cmd_type  cmd
);

   import cpfm_pkg::*;

   localparam int SW = 4;
   localparam logic [SW-1:0] S_CLEAR = 4'd0;
   localparam logic [SW-1:0] S_IDLE  = 4'd1;
   localparam logic [SW-1:0] S_DISP  = 4'd2;
   localparam logic [SW-1:0] S_PENT  = 4'd3;
   localparam logic [SW-1:0] S_PCNT  = 4'd4;
   localparam logic [SW-1:0] S_DEC   = 4'd5;
   localparam logic [SW-1:0] S_SCAN  = 4'd6;
   localparam logic [SW-1:0] S_DOWN  = 4'd7;
   localparam logic [SW-1:0] S_UP    = 4'd8;
   localparam logic [SW-1:0] S_FRD   = 4'd9;
   localparam logic [SW-1:0] S_FENT  = 4'd10;
   localparam logic [SW-1:0] S_FCNT  = 4'd11;
   localparam logic [SW-1:0] S_FEND  = 4'd12;
   localparam logic [SW-1:0] S_RESP  = 4'd13;

   logic [SW-1:0]     state_ff, state_in;
   logic [STAT_W-1:0] code_ff, code_in;
   logic [PSEL_W-1:0] psel_ff, psel_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [OP_W-1:0]   op;

   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      psel_in      = psel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      op           = OP_NONE;
      req_ready    = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            op = OP_CLEAR;
            if (stat.walk_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op       = OP_ACCEPT;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            psel_in = PSEL_ZERO;
            code_in = ST_OK;
            if (stat.kind == KIND_SWITCH) begin
               op = OP_SWITCH;
               if (stat.sw_match) begin
                  state_in = S_RESP;
               end else if (stat.sw_full) begin
                  code_in  = ST_FULL;
                  state_in = S_RESP;
               end else begin
                  state_in = S_FRD;
               end
            end else if (stat.vpn_bad) begin
               code_in  = ST_NO_FAULT;
               state_in = S_RESP;
            end else begin
               op       = OP_PREAD;
               state_in = S_PENT;
            end
         end
         S_PENT: begin
            op       = OP_PENT;
            state_in = S_PCNT;
         end
         S_PCNT: begin
            op       = OP_PCNT;
            state_in = S_DEC;
         end
         S_DEC: begin
            priority if (stat.kind == KIND_ALLOC) begin
               state_in = S_SCAN;
            end else if (stat.kind == KIND_FREE) begin
               if (stat.e_valid) begin
                  op = OP_FREE;
               end
               state_in = S_RESP;
            end else if (!stat.e_valid || !stat.e_cow || stat.cnt_zero) begin
               code_in  = ST_NO_FAULT;
               state_in = S_RESP;
            end else if (stat.cnt_gt1) begin
               state_in = S_SCAN;
            end else begin
               op       = OP_UPGRADE;
               psel_in  = PSEL_ENTRY;
               state_in = S_RESP;
            end
         end
         S_SCAN: begin
            op = OP_SCAN;
            if (stat.scan_found) begin
               state_in = S_DOWN;
            end else if (stat.scan_end) begin
               code_in  = ST_NO_FRAME;
               state_in = S_RESP;
            end
         end
         S_DOWN: begin
            if (stat.e_valid) begin
               op = OP_DOWN;
            end
            state_in = S_UP;
         end
         S_UP: begin
            op       = OP_UP;
            psel_in  = PSEL_FREE;
            state_in = S_RESP;
         end
         S_FRD: begin
            op       = OP_FRD;
            state_in = S_FENT;
         end
         S_FENT: begin
            op       = OP_FENT;
            state_in = S_FCNT;
         end
         S_FCNT: begin
            op       = OP_FCNT;
            state_in = stat.walk_last ? S_FEND : S_FRD;
         end
         S_FEND: begin
            op       = OP_FEND;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               op           = OP_NONE;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
         code_ff      <= ST_OK;
         psel_ff      <= PSEL_ZERO;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         code_ff      <= code_in;
         psel_ff      <= psel_in;
      end
   end

   // The result register loads in the cycle the item leaves the response state.
   assign cmd.op    = (state_ff == S_RESP && (!rsp_valid_ff || rsp_ready)) ? OP_NONE : op;
   assign cmd.code  = code_ff;
   assign cmd.psel  = (state_ff == S_RESP && (!rsp_valid_ff || rsp_ready)) ? psel_ff
                                                                          : PSEL_HOLD;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/cpfm_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpfm_dp
// Datapath: page table and share count memories, frame scan, process table.
// ----------------------------------------------------------------------------
module cpfm_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  cpfm_pkg::ctrl_cmd_type         cmd,
   output cpfm_pkg::ctrl_stat_type        stat,
   input  logic [cpfm_pkg::KIND_W-1:0]    req_kind,
   input  logic [cpfm_pkg::VPN_W-1:0]     req_vpn,
   input  logic                          req_write_access,
   input  logic [cpfm_pkg::PID_W-1:0]     req_pid,
   output logic [cpfm_pkg::STAT_W-1:0]    rsp_status,
   output logic [cpfm_pkg::PFN_W-1:0]     rsp_pfn
);

   import cpfm_pkg::*;

   logic [KIND_W-1:0]  kind_ff;
   logic [VPN_W-1:0]   vpn_ff;
   logic               wr_ff;
   logic [PID_W-1:0]   reqpid_ff;
   page_entry_type     e_ff;
   logic [COUNT_W-1:0] cnt_ff;
   logic [FRAME_W-1:0] f_ff;
   logic [FRAME_W-1:0] sc_ff;
   logic [PAGE_W-1:0]  v_ff, v_in;
   logic [SLOT_W-1:0]  cur_ff, cur_in;
   logic [SLOT_W-1:0]  child_ff;
   logic [MAX_PROCS-1:0] used_ff, used_in;
   logic [PID_W-1:0]   pids_ff [MAX_PROCS];
   logic [NUM_FRAMES-1:0] nz_ff, nz_in;
   logic [STAT_W-1:0]  rsp_status_ff;
   logic [PFN_W-1:0]   rsp_pfn_ff;

   logic               page_we, page_re;
   logic [PADDR_W-1:0] page_waddr, page_raddr;
   page_entry_type     page_wdata;
   logic [ENTRY_W-1:0] page_rdata;
   page_entry_type     rd_e;
   logic               cnt_we, cnt_re;
   logic [FRAME_W-1:0] cnt_waddr, cnt_raddr;
   logic [COUNT_W-1:0] cnt_wdata, cnt_rdata;

   logic [COUNT_W-1:0] cnt_dec, cnt_cur, cnt_inc;
   logic               match_hit, free_hit;
   logic [SLOT_W-1:0]  match_slot, free_slot;
   page_entry_type     child_e;

   assign rd_e    = page_rdata;
   assign cnt_dec = (cnt_ff == '0) ? cnt_ff : cnt_ff - COUNT_W'(1);
   assign cnt_cur = nz_ff[e_ff.frame] ? cnt_rdata : '0;
   assign cnt_inc = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + COUNT_W'(1);

   always_comb begin
      match_hit  = 1'b0;
      match_slot = '0;
      free_hit   = 1'b0;
      free_slot  = '0;
      for (int i = MAX_PROCS - 1; i >= 0; i--) begin
         if (used_ff[i] && pids_ff[i] == reqpid_ff) begin
            match_hit  = 1'b1;
            match_slot = SLOT_W'(i);
         end
         if (!used_ff[i]) begin
            free_hit  = 1'b1;
            free_slot = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      child_e = '0;
      if (rd_e.valid) begin
         child_e.valid = 1'b1;
         child_e.cow   = rd_e.writable || rd_e.cow;
         child_e.frame = rd_e.frame;
      end
   end

   always_comb begin
      page_we    = 1'b0;
      page_waddr = {cur_ff, vpn_ff[PAGE_W-1:0]};
      page_wdata = '0;
      page_re    = 1'b0;
      page_raddr = {cur_ff, vpn_ff[PAGE_W-1:0]};
      cnt_we     = 1'b0;
      cnt_waddr  = e_ff.frame;
      cnt_wdata  = cnt_dec;
      cnt_re     = 1'b0;
      cnt_raddr  = rd_e.frame;
      v_in       = v_ff;
      cur_in     = cur_ff;
      used_in    = used_ff;
      unique case (cmd.op)
         OP_CLEAR: begin
            page_we    = 1'b1;
            page_waddr = {SLOT_W'(0), v_ff};
            v_in       = v_ff + PAGE_W'(1);
         end
         OP_ACCEPT: begin
            v_in = '0;
         end
         OP_PREAD: begin
            page_re = 1'b1;
         end
         OP_PENT, OP_FENT: begin
            cnt_re = 1'b1;
            if (cmd.op == OP_FENT) begin
               page_we    = 1'b1;
               page_waddr = {child_ff, v_ff};
               page_wdata = child_e;
            end
         end
         OP_DOWN: begin
            cnt_we = 1'b1;
         end
         OP_FREE: begin
            cnt_we  = 1'b1;
            page_we = 1'b1;
         end
         OP_UP: begin
            cnt_we              = 1'b1;
            cnt_waddr           = f_ff;
            cnt_wdata           = COUNT_W'(1);
            page_we             = 1'b1;
            page_wdata.valid    = 1'b1;
            page_wdata.writable = (kind_ff == KIND_ALLOC) ? wr_ff : 1'b1;
            page_wdata.frame    = f_ff;
         end
         OP_UPGRADE: begin
            page_we             = 1'b1;
            page_wdata.valid    = 1'b1;
            page_wdata.writable = 1'b1;
            page_wdata.frame    = e_ff.frame;
         end
         OP_SWITCH: begin
            if (match_hit) begin
               cur_in = match_slot;
            end
         end
         OP_FRD: begin
            page_re    = 1'b1;
            page_raddr = {cur_ff, v_ff};
         end
         OP_FCNT: begin
            cnt_we           = e_ff.valid;
            cnt_wdata        = cnt_inc;
            page_we          = e_ff.valid && (e_ff.writable || e_ff.cow);
            page_waddr       = {cur_ff, v_ff};
            page_wdata.valid = 1'b1;
            page_wdata.cow   = 1'b1;
            page_wdata.frame = e_ff.frame;
            v_in             = v_ff + PAGE_W'(1);
         end
         OP_FEND: begin
            used_in[child_ff] = 1'b1;
            cur_in            = child_ff;
         end
         default: begin
         end
      endcase
      nz_in = nz_ff;
      if (cnt_we) begin
         nz_in[cnt_waddr] = (cnt_wdata != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff    <= '0;
         cur_ff  <= '0;
         used_ff <= MAX_PROCS'(1);
         nz_ff   <= '0;
         for (int i = 0; i < MAX_PROCS; i++) begin
            pids_ff[i] <= '0;
         end
      end else begin
         v_ff    <= v_in;
         cur_ff  <= cur_in;
         used_ff <= used_in;
         nz_ff   <= nz_in;
         if (cmd.op == OP_FEND) begin
            pids_ff[child_ff] <= reqpid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_ACCEPT) begin
         kind_ff   <= req_kind;
         vpn_ff    <= req_vpn;
         wr_ff     <= req_write_access;
         reqpid_ff <= req_pid;
         sc_ff     <= '0;
      end
      if (cmd.op == OP_PENT || cmd.op == OP_FENT) begin
         e_ff <= rd_e;
      end
      if (cmd.op == OP_PCNT) begin
         cnt_ff <= cnt_cur;
      end
      if (cmd.op == OP_SCAN) begin
         f_ff  <= sc_ff;
         sc_ff <= sc_ff + FRAME_W'(1);
      end
      if (cmd.op == OP_SWITCH) begin
         child_ff <= free_slot;
      end
      if (cmd.psel != PSEL_HOLD) begin
         rsp_status_ff <= cmd.code;
         unique case (cmd.psel)
            PSEL_FREE:  rsp_pfn_ff <= PFN_W'(f_ff);
            PSEL_ENTRY: rsp_pfn_ff <= PFN_W'(e_ff.frame);
            default:    rsp_pfn_ff <= '0;
         endcase
      end
   end

   cpfm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (PDEPTH)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (page_we),
      .wr_addr (page_waddr),
      .wr_data (page_wdata),
      .rd_en   (page_re),
      .rd_addr (page_raddr),
      .rd_data (page_rdata)
   );

   cpfm_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (NUM_FRAMES)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_en   (cnt_re),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rdata)
   );

   assign stat.kind       = kind_ff;
   assign stat.vpn_bad    = (32'(vpn_ff) >= PAGES_KEPT);
   assign stat.e_valid    = e_ff.valid;
   assign stat.e_cow      = e_ff.cow;
   assign stat.cnt_zero   = (cnt_ff == '0);
   assign stat.cnt_gt1    = (cnt_ff > COUNT_W'(1));
   assign stat.scan_found = !nz_ff[sc_ff];
   assign stat.scan_end   = (32'(sc_ff) == NUM_FRAMES - 1);
   assign stat.sw_match   = match_hit;
   assign stat.sw_full    = !free_hit;
   assign stat.walk_last  = (32'(v_ff) == PAGES_KEPT - 1);

   assign rsp_status = rsp_status_ff;
   assign rsp_pfn    = rsp_pfn_ff;

endmodule

// ===== rtl/cow_page_frame_manager.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cow_page_frame_manager
// Copy-on-write page frame manager: per-process page tables and frame sharing.
// ----------------------------------------------------------------------------
// One item at a time. Free and upgrade pass through dispatch, entry read, count read
// and decode to the result; allocate and a copying fault add the lowest-free-frame scan,
// one frame per cycle (up to 128 frames), then the count down and up steps. A switch to a
// known process goes from dispatch to the result; a fork walks the current page table
// through the page memory, reading, copying and counting each entry. Reset is synchronous;
// afterwards a pass over all 256 entries clears process 0's page table and no item is accepted until it ends.
module cow_page_frame_manager (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [cpfm_pkg::KIND_W-1:0] req_kind,
   input  logic [cpfm_pkg::VPN_W-1:0]  req_vpn,
   input  logic                       req_write_access,
   input  logic [cpfm_pkg::PID_W-1:0]  req_pid,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [cpfm_pkg::STAT_W-1:0] rsp_status,
   output logic [cpfm_pkg::PFN_W-1:0]  rsp_pfn
);

   import cpfm_pkg::*;

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   cpfm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cpfm_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_kind         (req_kind),
      .req_vpn          (req_vpn),
      .req_write_access (req_write_access),
      .req_pid          (req_pid),
      .rsp_status       (rsp_status),
      .rsp_pfn          (rsp_pfn)
   );

endmodule
